@@ design/shdf_pkg.sv @@
// Package for the seen-hash duplicate filter.
// Holds field widths, parameter defaults and the sequencer state type.
// No dependencies.
`default_nettype none

package shdf_pkg;

  // Default sizing of the hash table
  localparam int TABLE_DEPTH_DEF = 128;
  localparam int HASH_BITS_DEF   = 64;

  // Fixed field widths of the request and result channels
  localparam int PACKET_HASH_W = 64;
  localparam int OCCUPANCY_W   = 8;

  // Scan sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } shdf_state_t;

endpackage

`default_nettype wire

@@ design/shdf_if.sv @@
// Valid/ready channel interfaces of the seen-hash duplicate filter.
// Depends on shdf_pkg for the payload widths.
`default_nettype none

// Request channel: one packet hash per request
interface shdf_hash_if;
  logic                               valid;
  logic                               ready;
  logic [shdf_pkg::PACKET_HASH_W-1:0] packet_hash;

  modport source (output valid, output packet_hash, input ready);
  modport sink (input valid, input packet_hash, output ready);
endinterface

// Result channel: verdict and table occupancy for each request
interface shdf_result_if;
  logic                             valid;
  logic                             ready;
  logic                             accepted;
  logic                             recorded;
  logic [shdf_pkg::OCCUPANCY_W-1:0] occupancy;

  modport source (output valid, output accepted, output recorded, output occupancy,
                  input ready);
  modport sink (input valid, input accepted, input recorded, input occupancy,
                output ready);
endinterface

`default_nettype wire

@@ design/shdf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module shdf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic                                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/seen_hash_duplicate_filter.sv @@
// Seen-hash duplicate filter. Each request carries a packet hash; the block
// scans the hashes stored so far, one table entry per clock through a single
// comparator, and reports the packet as accepted (new) or dropped (duplicate).
// A new hash is appended while the table has room; a full table still accepts
// new hashes but records nothing, and entries are never evicted. The scan reads
// the stored hashes in turn, limited by the single RAM read port and the one
// comparator, and stops at the first match; with an empty table the scan is
// skipped. The next request is taken once the sequencer is back in idle.
// Only the low HASH_BITS bits of the hash take part. The result sits in an
// output register, so a new request is taken while an earlier result waits.
// Depends on shdf_pkg, shdf_if and shdf_ram.
`default_nettype none

module seen_hash_duplicate_filter #(
  parameter int TABLE_DEPTH = shdf_pkg::TABLE_DEPTH_DEF,
  parameter int HASH_BITS   = shdf_pkg::HASH_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  shdf_hash_if.sink     hash_req,
  shdf_result_if.source verdict
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  shdf_pkg::shdf_state_t state, state_next;

  logic [HASH_BITS-1:0] hash;
  logic [HASH_BITS-1:0] rd_data;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic                 chk;
  logic                 seen;

  logic                 res_valid;
  logic                 res_accepted;
  logic                 res_recorded;
  logic [shdf_pkg::OCCUPANCY_W-1:0] res_occupancy;

  logic                 req_take;
  logic                 res_free;
  logic                 full;
  logic                 match;
  logic                 rd_en;
  logic                 wr_en;
  logic                 in_ready;
  logic [31:0]          occ_wide;

  // Hash table
  shdf_ram #(
    .WIDTH (HASH_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[AW-1:0]),
    .wdata (hash),
    .re    (rd_en),
    .raddr (idx[AW-1:0]),
    .rdata (rd_data)
  );

  // Shared comparator and status terms
  assign match    = (rd_data == hash);
  assign full     = (count == CW'(TABLE_DEPTH));
  assign res_free = !res_valid || verdict.ready;
  assign req_take = hash_req.valid && in_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      shdf_pkg::ST_IDLE: begin
        if (req_take) begin
          state_next = (count == '0) ? shdf_pkg::ST_FINISH : shdf_pkg::ST_SCAN;
        end
      end
      shdf_pkg::ST_SCAN: begin
        if ((chk && match) || (idx == count)) begin
          state_next = shdf_pkg::ST_FINISH;
        end
      end
      shdf_pkg::ST_FINISH: begin
        if (res_free) begin
          state_next = shdf_pkg::ST_IDLE;
        end
      end
      default: state_next = shdf_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    unique case (state)
      shdf_pkg::ST_IDLE:   in_ready = 1'b1;
      shdf_pkg::ST_SCAN:   rd_en    = (idx < count);
      shdf_pkg::ST_FINISH: wr_en    = res_free && !seen && !full;
      default: ;
    endcase
  end

  assign count_next = count + CW'(wr_en);
  assign occ_wide   = 32'(count_next);

  // State, count and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= shdf_pkg::ST_IDLE;
      count <= '0;
      chk   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      chk   <= rd_en;
    end
  end

  // Request hash, scan index and match flag
  always_ff @(posedge clk) begin
    if (req_take) begin
      hash <= hash_req.packet_hash[HASH_BITS-1:0];
      idx  <= '0;
      seen <= 1'b0;
    end else if (state == shdf_pkg::ST_SCAN) begin
      if (rd_en) begin
        idx <= idx + CW'(1);
      end
      if (chk && match) begin
        seen <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == shdf_pkg::ST_FINISH) && res_free) begin
      res_valid <= 1'b1;
    end else if (verdict.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == shdf_pkg::ST_FINISH) && res_free) begin
      res_accepted  <= !seen;
      res_recorded  <= wr_en;
      res_occupancy <= occ_wide[shdf_pkg::OCCUPANCY_W-1:0];
    end
  end

  assign hash_req.ready    = in_ready;
  assign verdict.valid     = res_valid;
  assign verdict.accepted  = res_accepted;
  assign verdict.recorded  = res_recorded;
  assign verdict.occupancy = res_occupancy;

endmodule

`default_nettype wire
